[sv/prtt_pkg.sv]
`default_nettype none

package prtt_pkg;

    // Command codes
    localparam logic [2:0] CMD_OPEN    = 3'd0;
    localparam logic [2:0] CMD_ADD_SEG = 3'd1;
    localparam logic [2:0] CMD_COMMIT  = 3'd2;
    localparam logic [2:0] CMD_REMOVE  = 3'd3;
    localparam logic [2:0] CMD_LOOKUP  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ARG    = 3'd1;
    localparam logic [2:0] ST_NO_SPACE   = 3'd2;
    localparam logic [2:0] ST_IO_ERROR   = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  owner_id;
        logic [47:0] virt_addr;
        logic [47:0] region_length;
        logic [47:0] seg_phys;
        logic [47:0] seg_len;
        logic [15:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] handle_out;
        logic [47:0] phys_out;
        logic        found;
    } rsp_t;

    typedef struct packed {
        logic [47:0] phys;
        logic [47:0] len;
    } seg_t;

    // Controller to datapath
    typedef struct packed {
        logic       take;
        logic       do_open;
        logic       do_add;
        logic       cm_check;
        logic       cp_rd;
        logic       cp_wr;
        logic       cm_fin;
        logic       scan_init;
        logic       scan_rd;
        logic       scan_next;
        logic       rm_shift;
        logic       lk_a;
        logic       seg_init;
        logic       sg_rd;
        logic       sg_a;
        logic       sg_next;
        logic       sg_out;
        logic       set_st;
        logic [2:0] st;
        logic       load_out;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       cm_go;
        logic       tbl_empty;
        logic       scan_last;
        logic       handle_hit;
        logic       lk_hit;
        logic       seg_none;
        logic       seg_last;
        logic       seg_hit;
        logic       pend_last;
        logic       out_free;
    } ctl_stat_t;

endpackage

`default_nettype wire

[sv/prtt_ctrl.sv]
`default_nettype none

module prtt_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_ready,
    input  prtt_pkg::ctl_stat_t  stat,
    output prtt_pkg::ctl_cmd_t   cmd
);
    import prtt_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_CP_RD    = 4'd2;
    localparam logic [3:0] S_CP_WR    = 4'd3;
    localparam logic [3:0] S_CM_FIN   = 4'd4;
    localparam logic [3:0] S_SC_RD    = 4'd5;
    localparam logic [3:0] S_RM_CHK   = 4'd6;
    localparam logic [3:0] S_RM_SHIFT = 4'd7;
    localparam logic [3:0] S_LK_A     = 4'd8;
    localparam logic [3:0] S_LK_B     = 4'd9;
    localparam logic [3:0] S_SG_RD    = 4'd10;
    localparam logic [3:0] S_SG_A     = 4'd11;
    localparam logic [3:0] S_SG_B     = 4'd12;
    localparam logic [3:0] S_SG_OUT   = 4'd13;
    localparam logic [3:0] S_FIN      = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.cmd)
                    CMD_OPEN:
                    begin
                        cmd.do_open = 1'b1;
                        state_next  = S_FIN;
                    end
                    CMD_ADD_SEG:
                    begin
                        cmd.do_add = 1'b1;
                        state_next = S_FIN;
                    end
                    CMD_COMMIT:
                    begin
                        cmd.cm_check = 1'b1;
                        state_next   = stat.cm_go ? S_CP_RD : S_FIN;
                    end
                    CMD_REMOVE, CMD_LOOKUP:
                    begin
                        cmd.scan_init = 1'b1;
                        if (stat.tbl_empty)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = ST_NOT_FOUND;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SC_RD;
                        end
                    end
                    default:
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_BAD_ARG;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_CP_RD:
            begin
                cmd.cp_rd  = 1'b1;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                cmd.cp_wr  = 1'b1;
                state_next = stat.pend_last ? S_CM_FIN : S_CP_RD;
            end
            S_CM_FIN:
            begin
                cmd.cm_fin = 1'b1;
                state_next = S_FIN;
            end
            S_SC_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = (stat.cmd == CMD_REMOVE) ? S_RM_CHK : S_LK_A;
            end
            S_RM_CHK:
            begin
                priority if (stat.handle_hit)
                begin
                    state_next = S_RM_SHIFT;
                end
                else if (stat.scan_last)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_NOT_FOUND;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SC_RD;
                end
            end
            S_RM_SHIFT:
            begin
                cmd.rm_shift = 1'b1;
                state_next   = S_FIN;
            end
            S_LK_A:
            begin
                cmd.lk_a   = 1'b1;
                state_next = S_LK_B;
            end
            S_LK_B:
            begin
                priority if (stat.lk_hit)
                begin
                    cmd.seg_init = 1'b1;
                    state_next   = stat.seg_none ? S_FIN : S_SG_RD;
                end
                else if (stat.scan_last)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_NOT_FOUND;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SC_RD;
                end
            end
            S_SG_RD:
            begin
                cmd.sg_rd  = 1'b1;
                state_next = S_SG_A;
            end
            S_SG_A:
            begin
                cmd.sg_a   = 1'b1;
                state_next = S_SG_B;
            end
            S_SG_B:
            begin
                if (stat.seg_hit)
                begin
                    state_next = S_SG_OUT;
                end
                else
                begin
                    cmd.sg_next = 1'b1;
                    state_next  = stat.seg_last ? S_FIN : S_SG_RD;
                end
            end
            S_SG_OUT:
            begin
                cmd.sg_out = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[sv/prtt_dpath.sv]
`default_nettype none

module prtt_dpath #(
    parameter int MAX_REGIONS  = 16,
    parameter int MAX_SEGMENTS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  prtt_pkg::req_t       req,
    input  prtt_pkg::ctl_cmd_t   cmd,
    output prtt_pkg::ctl_stat_t  stat,
    output prtt_pkg::rsp_t       rsp,
    output logic                 rsp_valid,
    input  wire                  rsp_ready
);
    import prtt_pkg::*;

    localparam int RW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int RCW  = $clog2(MAX_REGIONS + 1);
    localparam int SW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SCW  = $clog2(MAX_SEGMENTS + 1);
    localparam int SEGS = MAX_REGIONS * MAX_SEGMENTS;
    localparam int AW   = (SEGS > 1) ? $clog2(SEGS) : 1;

    typedef struct packed {
        logic [7:0]     owner;
        logic [47:0]    base;
        logic [47:0]    length;
        logic [SCW-1:0] seg_cnt;
        logic [15:0]    handle;
    } meta_t;

    req_t           item_reg;
    rsp_t           res_reg;
    rsp_t           rsp_reg;
    logic           rsp_valid_reg;

    logic [7:0]     pend_owner_reg;
    logic [47:0]    pend_base_reg;
    logic [47:0]    pend_length_reg;
    logic [SCW-1:0] pend_cnt_reg;
    logic [47:0]    pend_sum_reg;

    seg_t           pend_mem [MAX_SEGMENTS];
    seg_t           pend_rd_reg;
    seg_t           seg_mem [SEGS];
    seg_t           seg_rd_reg;
    meta_t          meta_mem [MAX_REGIONS];
    meta_t          meta_rd_reg;

    logic [RW-1:0]  order_reg [MAX_REGIONS];
    logic [RCW-1:0] count_reg;
    logic [15:0]    next_handle_reg;
    logic [RW-1:0]  i_reg;
    logic [SCW-1:0] s_reg;
    logic [RW-1:0]  slot_reg;
    logic [47:0]    off_reg;
    logic           pre_ok_reg;
    logic [47:0]    acc_reg;
    logic [48:0]    accsum_reg;
    logic [47:0]    diff_reg;

    logic [RW-1:0]  ord_idx;
    logic [RW-1:0]  ord_sel;
    logic [AW-1:0]  seg_addr;
    logic [48:0]    sum_ext;
    logic           cm_bad;
    logic           tbl_full;

    assign ord_idx  = cmd.cm_check ? count_reg[RW-1:0] : i_reg;
    assign ord_sel  = order_reg[ord_idx];
    assign seg_addr = AW'(slot_reg) * AW'(MAX_SEGMENTS) + AW'(s_reg);
    assign sum_ext  = {1'b0, pend_sum_reg} + {1'b0, item_reg.seg_len};
    assign cm_bad   = (pend_cnt_reg == '0) || (pend_sum_reg != pend_length_reg);
    assign tbl_full = (count_reg >= RCW'(MAX_REGIONS));

    always_comb
    begin
        stat            = '0;
        stat.cmd        = item_reg.cmd;
        stat.cm_go      = !cm_bad && !tbl_full;
        stat.tbl_empty  = (count_reg == '0);
        stat.scan_last  = ((RCW'(i_reg) + RCW'(1)) >= count_reg);
        stat.handle_hit = (meta_rd_reg.handle == item_reg.handle_in);
        stat.lk_hit     = pre_ok_reg && (off_reg < meta_rd_reg.length);
        stat.seg_none   = (meta_rd_reg.seg_cnt == '0);
        stat.seg_last   = (({1'b0, s_reg} + (SCW+1)'(1)) >= {1'b0, meta_rd_reg.seg_cnt});
        stat.seg_hit    = ({1'b0, off_reg} < accsum_reg);
        stat.pend_last  = (({1'b0, s_reg} + (SCW+1)'(1)) >= {1'b0, pend_cnt_reg});
        stat.out_free   = !rsp_valid_reg || rsp_ready;
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (cmd.do_add && (pend_cnt_reg < SCW'(MAX_SEGMENTS)))
        begin
            pend_mem[pend_cnt_reg[SW-1:0]] <= {item_reg.seg_phys, item_reg.seg_len};
        end
        if (cmd.cp_rd)
        begin
            pend_rd_reg <= pend_mem[s_reg[SW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cp_wr)
        begin
            seg_mem[seg_addr] <= pend_rd_reg;
        end
        if (cmd.sg_rd)
        begin
            seg_rd_reg <= seg_mem[seg_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cm_fin)
        begin
            meta_mem[slot_reg] <= '{owner:   pend_owner_reg,
                                    base:    pend_base_reg,
                                    length:  pend_length_reg,
                                    seg_cnt: pend_cnt_reg,
                                    handle:  next_handle_reg};
        end
        if (cmd.scan_rd)
        begin
            meta_rd_reg <= meta_mem[ord_sel];
        end
    end

    // Payload and scratch registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= req;
            res_reg  <= '0;
        end
        if (cmd.set_st)
        begin
            res_reg.status <= cmd.st;
        end
        if (cmd.do_open && (item_reg.region_length == '0))
        begin
            res_reg.status <= ST_BAD_ARG;
        end
        if (cmd.cm_check)
        begin
            slot_reg <= ord_sel;
            s_reg    <= '0;
            if (cm_bad)
            begin
                res_reg.status <= (pend_cnt_reg == SCW'(MAX_SEGMENTS)) ? ST_NO_SPACE
                                                                       : ST_IO_ERROR;
            end
            else if (tbl_full)
            begin
                res_reg.status <= ST_TABLE_FULL;
            end
        end
        if (cmd.cp_wr)
        begin
            s_reg <= s_reg + SCW'(1);
        end
        if (cmd.cm_fin)
        begin
            res_reg.handle_out <= next_handle_reg;
        end
        if (cmd.scan_rd)
        begin
            slot_reg <= ord_sel;
        end
        if (cmd.lk_a)
        begin
            pre_ok_reg <= (meta_rd_reg.owner == item_reg.owner_id) &&
                          (item_reg.virt_addr >= meta_rd_reg.base);
            off_reg    <= item_reg.virt_addr - meta_rd_reg.base;
        end
        if (cmd.seg_init)
        begin
            s_reg         <= '0;
            acc_reg       <= '0;
            res_reg.found <= 1'b1;
        end
        if (cmd.sg_a)
        begin
            accsum_reg <= {1'b0, acc_reg} + {1'b0, seg_rd_reg.len};
            diff_reg   <= off_reg - acc_reg;
        end
        if (cmd.sg_next)
        begin
            acc_reg <= accsum_reg[47:0];
            s_reg   <= s_reg + SCW'(1);
        end
        if (cmd.sg_out)
        begin
            res_reg.phys_out <= seg_rd_reg.phys + diff_reg;
        end
        if (cmd.load_out)
        begin
            rsp_reg <= res_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_owner_reg  <= '0;
            pend_base_reg   <= '0;
            pend_length_reg <= '0;
            pend_cnt_reg    <= '0;
            pend_sum_reg    <= '0;
            count_reg       <= '0;
            next_handle_reg <= '0;
            i_reg           <= '0;
            rsp_valid_reg   <= 1'b0;
            for (int k = 0; k < MAX_REGIONS; k++)
            begin
                order_reg[RW'(k)] <= RW'(k);
            end
        end
        else
        begin
            if (cmd.do_open && (item_reg.region_length != '0))
            begin
                pend_owner_reg  <= item_reg.owner_id;
                pend_base_reg   <= item_reg.virt_addr;
                pend_length_reg <= item_reg.region_length;
                pend_cnt_reg    <= '0;
                pend_sum_reg    <= '0;
            end
            if (cmd.do_add && (pend_cnt_reg < SCW'(MAX_SEGMENTS)))
            begin
                pend_cnt_reg <= pend_cnt_reg + SCW'(1);
                pend_sum_reg <= sum_ext[48] ? {48{1'b1}} : sum_ext[47:0];
            end
            if ((cmd.cm_check && (cm_bad || tbl_full)) || cmd.cm_fin)
            begin
                pend_length_reg <= '0;
                pend_cnt_reg    <= '0;
                pend_sum_reg    <= '0;
            end
            if (cmd.cm_fin)
            begin
                count_reg       <= count_reg + RCW'(1);
                next_handle_reg <= next_handle_reg + 16'd1;
            end
            if (cmd.scan_init)
            begin
                i_reg <= '0;
            end
            if (cmd.scan_next)
            begin
                i_reg <= i_reg + RW'(1);
            end
            // Slot of the removed region moves to the end of the live list
            if (cmd.rm_shift)
            begin
                count_reg <= count_reg - RCW'(1);
                for (int k = 0; k < MAX_REGIONS; k++)
                begin
                    if ((RCW'(k) >= RCW'(i_reg)) && ((RCW'(k) + RCW'(1)) < count_reg))
                    begin
                        order_reg[RW'(k)] <= order_reg[RW'((k + 1) % MAX_REGIONS)];
                    end
                    else if ((RCW'(k) + RCW'(1)) == count_reg)
                    begin
                        order_reg[RW'(k)] <= slot_reg;
                    end
                end
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

[sv/pinned_region_translation_table.sv]
// Pinned-region translation table.
// Request channel (req_valid/req_ready/req) carries one command per transfer:
// open, add_segment, commit, remove or lookup. Response channel
// (rsp_valid/rsp_ready/rsp) returns exactly one result per request.
// One request is in flight at a time; req_ready is high while the
// controller is idle, even if the previous response is still waiting.
// Steps per request, from accept to the finish state:
//   open, add_segment, bad commit, unknown code: dispatch only
//   good commit: pending list copied one entry per read and write step
//   remove: a read and a check per region scanned, a shift on a hit
//   lookup: a read and two compare steps per region and per segment walked
// The region scan and segment walk go through single-port memories, one
// entry per step; a lookup on a hit also takes an output step.
// A stalled receiver holds the response register; the next request may be
// taken but its response waits in the finish state until rsp_ready.
// Reset clears the pending region, region count and handle counter; the
// region and segment memories need no clearing.
`default_nettype none

module pinned_region_translation_table #(
    parameter int MAX_REGIONS  = 16,
    parameter int MAX_SEGMENTS = 16
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              req_valid,
    output logic             req_ready,
    input  prtt_pkg::req_t   req,
    output logic             rsp_valid,
    input  wire              rsp_ready,
    output prtt_pkg::rsp_t   rsp
);
    import prtt_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // Sequencer: one state per step of each command
    prtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Pending buffer, region order list, memories and response register
    prtt_dpath #(
        .MAX_REGIONS  (MAX_REGIONS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule

`default_nettype wire
